// File: rtl/icr_pkg.sv
// Shared types, constants and register codes for the replicate-edge convolution core.
package icr_pkg;

	// Default geometry and arithmetic settings.
	localparam int KSIZE_DEF      = 3;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int COEF_FRAC_DEF  = 8;

	// Fixed field widths.
	localparam int CH_W      = 8;
	localparam int PIX_W     = 32;
	localparam int COEF_W    = 12;
	localparam int COEF_ROWS = 5;
	localparam int CFG_W     = 60;
	localparam int CFG_IDX_W = 3;
	localparam int GEOM_W    = 11;
	localparam int CHCNT_W   = 3;

	// Arithmetic widths: 9-bit signed pixel times 12-bit coefficient, then up to
	// five terms per kernel row and five rows.
	localparam int PROD_W = 21;
	localparam int RSUM_W = 24;
	localparam int SUM_W  = 27;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW1     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW3     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW4     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd7;

	// Request command codes.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef struct packed {
		logic            cmd;
		logic [CH_W-1:0] chan0_in;
		logic [CH_W-1:0] chan1_in;
		logic [CH_W-1:0] chan2_in;
		logic [CH_W-1:0] chan3_in;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0] chan0_out;
		logic [CH_W-1:0] chan1_out;
		logic [CH_W-1:0] chan2_out;
		logic [CH_W-1:0] chan3_out;
		logic            frame_last;
	} out_item_t;

	// Line store control: pipeline advance, column fetch and pixel write.
	typedef struct packed {
		logic adv;
		logic fetch;
		logic wr;
	} win_ctrl_t;

endpackage

// File: rtl/image_convolution_replicate_edge_core.sv
// Top level of the replicate-edge 2-D convolution core.
//
//   channel  direction  handshake          payload
//   pix      in         pix_valid/stall    in_item_t  (pixel or flush request)
//   res      out        res_valid/stall    out_item_t (convolved pixel)
//   cfg      in         cfg_wen            cfg_index, cfg_wdata
//
// One request is taken per clock while pix_stall is low; results pass stages s1 to s5
// and the output register, and trail pixels by PAD*width+PAD requests.
// Reset sets the configuration to its defaults and clears counters and valid flags; the row store is not cleared.
// A stalled result in the output register with another result behind it halts the
// whole pipeline and raises pix_stall; otherwise requests keep flowing.
module image_convolution_replicate_edge_core import icr_pkg::*; #(
	parameter int KSIZE = KSIZE_DEF,
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int COEF_FRAC = COEF_FRAC_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  in_item_t             pix_data,
	output logic                 res_valid,
	input  logic                 res_stall,
	output out_item_t            res_data,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int PAD    = KSIZE / 2;
	localparam int WK     = 2 * PAD + 1;
	localparam int NSLOT  = 2 * PAD + 2;
	localparam int SLOT_W = $clog2(NSLOT);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int IROW_W = $clog2(MAX_HEIGHT + KSIZE + 2);
	localparam int DLY_W  = $clog2(PAD * MAX_WIDTH + PAD + 2);
	localparam int SEL_W  = (WK > 1) ? $clog2(WK) : 1;
	localparam int NTAP   = KSIZE * KSIZE;
	localparam int NLANE  = 3;

	logic [CFG_W-1:0]   coef_q [COEF_ROWS];
	logic [GEOM_W-1:0]  width_q;
	logic [GEOM_W-1:0]  height_q;
	logic [CHCNT_W-1:0] chcnt_q;
	logic               restart_cfg;

	logic [WW-1:0]      w_eff;
	logic [HW-1:0]      h_eff;
	logic [CHCNT_W-1:0] ch_eff;
	logic [CHCNT_W-1:0] nconv;

	logic [COL_W-1:0]   in_col_q;
	logic [IROW_W-1:0]  in_row_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [DLY_W-1:0]   pre_q;
	logic [ROW_W-1:0]   out_r_q;
	logic [COL_W-1:0]   out_c_q;

	logic               adv, acc, in_frame, proc, wr, emit, last, col_wrap, ocol_wrap;
	logic [DLY_W-1:0]   delay;
	logic [SEL_W-1:0]   rsel [KSIZE];
	logic [SEL_W-1:0]   csel [KSIZE];
	logic [SEL_W-1:0]   rsel_s1 [KSIZE];
	logic [SEL_W-1:0]   csel_s1 [KSIZE];
	win_ctrl_t          ctrl;

	logic               o_s1, v_s2, v_s3, v_s4, v_s5;
	logic               last_s1, last_s2, last_s3, last_s4, last_s5;
	logic [CH_W-1:0]    alpha_s3, alpha_s4, alpha_s5;

	logic [PIX_W-1:0]          sel_pix [NTAP];
	logic signed [COEF_W-1:0]  coef [NTAP];
	logic [CH_W-1:0]           lane_pix [NLANE][NTAP];
	logic signed [SUM_W-1:0]   lane_sum [NLANE];

	logic                      out_valid_q;
	out_item_t                 out_q;

	// Saturate a fixed-point sum to a byte, truncating toward zero.
	function automatic logic [CH_W-1:0] sat8(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] q;
		q = s >>> COEF_FRAC;
		if (s <= 0) begin
			return '0;
		end
		if (q > 255) begin
			return '1;
		end
		return q[CH_W-1:0];
	endfunction

	// Configuration registers.
	assign restart_cfg = cfg_wen &&
		(cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_ROWS; i++) begin
				coef_q[i] <= '0;
			end
			width_q  <= GEOM_W'(1024);
			height_q <= GEOM_W'(1024);
			chcnt_q  <= CHCNT_W'(3);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_COEF_ROW0:     coef_q[0] <= cfg_wdata;
				REG_COEF_ROW1:     coef_q[1] <= cfg_wdata;
				REG_COEF_ROW2:     coef_q[2] <= cfg_wdata;
				REG_COEF_ROW3:     coef_q[3] <= cfg_wdata;
				REG_COEF_ROW4:     coef_q[4] <= cfg_wdata;
				REG_IMAGE_WIDTH:   width_q   <= cfg_wdata[GEOM_W-1:0];
				REG_IMAGE_HEIGHT:  height_q  <= cfg_wdata[GEOM_W-1:0];
				REG_CHANNEL_COUNT: chcnt_q   <= cfg_wdata[CHCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective geometry and channel count after range limiting.
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
		if (chcnt_q == '0) begin
			ch_eff = CHCNT_W'(1);
		end else if (chcnt_q > CHCNT_W'(4)) begin
			ch_eff = CHCNT_W'(4);
		end else begin
			ch_eff = chcnt_q;
		end
		nconv = (ch_eff == CHCNT_W'(4)) ? CHCNT_W'(3) : ch_eff;
	end

	// Request handling: flushes inside the frame are dropped, late pixels act as flushes.
	assign adv       = !out_valid_q || !res_stall || !v_s5;
	assign pix_stall = !adv;
	assign acc       = pix_valid && adv;
	assign in_frame  = 32'(in_row_q) < 32'(h_eff);
	assign proc      = acc && !(in_frame && pix_data.cmd == CMD_FLUSH);
	assign wr        = proc && in_frame;
	assign delay     = DLY_W'(32'(PAD) * 32'(w_eff) + 32'(PAD));
	assign emit      = proc && (pre_q == delay);
	assign last      = (32'(out_r_q) == 32'(h_eff) - 32'd1) &&
		(32'(out_c_q) == 32'(w_eff) - 32'd1);
	assign col_wrap  = 32'(in_col_q) + 32'd1 >= 32'(w_eff);
	assign ocol_wrap = 32'(out_c_q) + 32'd1 >= 32'(w_eff);

	// Position counters for incoming requests and outgoing results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			slot_q   <= '0;
			pre_q    <= '0;
			out_r_q  <= '0;
			out_c_q  <= '0;
		end else if (restart_cfg || (emit && last)) begin
			in_col_q <= '0;
			in_row_q <= '0;
			slot_q   <= '0;
			pre_q    <= '0;
			out_r_q  <= '0;
			out_c_q  <= '0;
		end else if (proc) begin
			if (col_wrap) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + IROW_W'(1);
				slot_q   <= (slot_q == SLOT_W'(NSLOT - 1)) ? '0 : slot_q + SLOT_W'(1);
			end else begin
				in_col_q <= in_col_q + COL_W'(1);
			end
			if (pre_q != delay) begin
				pre_q <= pre_q + DLY_W'(1);
			end
			if (emit) begin
				if (ocol_wrap) begin
					out_c_q <= '0;
					out_r_q <= out_r_q + ROW_W'(1);
				end else begin
					out_c_q <= out_c_q + COL_W'(1);
				end
			end
		end
	end

	// Window tap selection for each kernel row and column, clamped to the image.
	always_comb begin
		int t;
		t = 0;
		for (int y = 0; y < KSIZE; y++) begin
			t = int'(out_r_q) - PAD + y;
			if (t < 0) begin
				rsel[y] = SEL_W'(PAD - int'(out_r_q));
			end else if (t > int'(h_eff) - 1) begin
				rsel[y] = SEL_W'(int'(h_eff) - 1 - int'(out_r_q) + PAD);
			end else begin
				rsel[y] = SEL_W'(y);
			end
		end
		for (int x = 0; x < KSIZE; x++) begin
			t = int'(out_c_q) - PAD + x;
			if (t < 0) begin
				csel[x] = SEL_W'(PAD - int'(out_c_q));
			end else if (t > int'(w_eff) - 1) begin
				csel[x] = SEL_W'(int'(w_eff) - 1 - int'(out_c_q) + PAD);
			end else begin
				csel[x] = SEL_W'(x);
			end
		end
	end

	// Result pipeline control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			o_s1 <= emit;
			v_s2 <= o_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Result side information travelling alongside the lanes.
	always_ff @(posedge clk) begin
		if (adv) begin
			rsel_s1  <= rsel;
			csel_s1  <= csel;
			last_s1  <= last;
			last_s2  <= last_s1;
			last_s3  <= last_s2;
			last_s4  <= last_s3;
			last_s5  <= last_s4;
			alpha_s3 <= sel_pix[PAD*KSIZE+PAD][PIX_W-1 -: CH_W];
			alpha_s4 <= alpha_s3;
			alpha_s5 <= alpha_s4;
		end
	end

	assign ctrl.adv   = adv;
	assign ctrl.fetch = proc;
	assign ctrl.wr    = wr;

	icr_line_store #(
		.KSIZE     (KSIZE),
		.MAX_WIDTH (MAX_WIDTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.slot    (slot_q),
		.col     (in_col_q),
		.wpix    ({pix_data.chan3_in, pix_data.chan2_in, pix_data.chan1_in,
			pix_data.chan0_in}),
		.rsel_s1 (rsel_s1),
		.csel_s1 (csel_s1),
		.sel_pix (sel_pix)
	);

	// Kernel coefficients unpacked from the row registers.
	always_comb begin
		for (int y = 0; y < KSIZE; y++) begin
			for (int x = 0; x < KSIZE; x++) begin
				coef[y*KSIZE+x] = signed'(coef_q[y][COEF_W*x +: COEF_W]);
			end
		end
	end

	// Channel lanes.
	for (genvar k = 0; k < NLANE; k++) begin : g_lane
		always_comb begin
			for (int t = 0; t < NTAP; t++) begin
				lane_pix[k][t] = sel_pix[t][CH_W*k +: CH_W];
			end
		end

		icr_lane #(
			.KSIZE (KSIZE)
		) u_lane (
			.clk    (clk),
			.en     (adv),
			.pix    (lane_pix[k]),
			.coef   (coef),
			.sum_s5 (lane_sum[k])
		);
	end

	// Merge the lanes into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !res_stall) begin
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !res_stall) begin
			out_q.chan0_out  <= sat8(lane_sum[0]);
			out_q.chan1_out  <= (nconv > CHCNT_W'(1)) ? sat8(lane_sum[1]) : '0;
			out_q.chan2_out  <= (nconv > CHCNT_W'(2)) ? sat8(lane_sum[2]) : '0;
			out_q.chan3_out  <= (ch_eff == CHCNT_W'(4)) ? alpha_s5 : '0;
			out_q.frame_last <= last_s5;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

endmodule

// File: rtl/icr_line_store.sv
// Banked row store, sliding pixel window and edge-clamping tap selection.
module icr_line_store import icr_pkg::*; #(
	parameter int KSIZE = KSIZE_DEF,
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int PAD = KSIZE / 2,
	localparam int WK = 2 * PAD + 1,
	localparam int NSLOT = 2 * PAD + 2,
	localparam int SLOT_W = $clog2(NSLOT),
	localparam int COL_W = $clog2(MAX_WIDTH),
	localparam int SEL_W = (WK > 1) ? $clog2(WK) : 1,
	localparam int NTAP = KSIZE * KSIZE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  win_ctrl_t         ctrl,
	input  logic [SLOT_W-1:0] slot,
	input  logic [COL_W-1:0]  col,
	input  logic [PIX_W-1:0]  wpix,
	input  logic [SEL_W-1:0]  rsel_s1 [KSIZE],
	input  logic [SEL_W-1:0]  csel_s1 [KSIZE],
	output logic [PIX_W-1:0]  sel_pix [NTAP]
);

	logic [PIX_W-1:0]  rd_s1 [NSLOT];
	logic [PIX_W-1:0]  pix_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              v_s1;
	logic [PIX_W-1:0]  newcol [WK];
	logic [PIX_W-1:0]  win_q [WK][WK];
	logic [SEL_W-1:0]  rsel_s2 [KSIZE];
	logic [SEL_W-1:0]  csel_s2 [KSIZE];

	// One row slot per bank; every bank reads the same column each request.
	for (genvar b = 0; b < NSLOT; b++) begin : g_bank
		logic [PIX_W-1:0] mem [MAX_WIDTH];

		always_ff @(posedge clk) begin
			if (ctrl.wr && slot == SLOT_W'(b)) begin
				mem[col] <= wpix;
			end
			if (ctrl.adv && ctrl.fetch) begin
				rd_s1[b] <= mem[col];
			end
		end
	end

	// The current row bypasses the store as it is being written this cycle.
	always_ff @(posedge clk) begin
		if (ctrl.adv && ctrl.fetch) begin
			pix_s1  <= wpix;
			slot_s1 <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ctrl.adv) begin
			v_s1 <= ctrl.fetch;
		end
	end

	// Assemble the new column: window row j holds the row 2*PAD-j above the current one.
	always_comb begin
		int sj;
		sj = 0;
		for (int j = 0; j < WK; j++) begin
			if (j == WK - 1) begin
				newcol[j] = pix_s1;
			end else begin
				sj = int'(slot_s1) + j + 2;
				if (sj >= NSLOT) begin
					sj = sj - NSLOT;
				end
				newcol[j] = rd_s1[sj[SLOT_W-1:0]];
			end
		end
	end

	// Shift the window one column per fetched request.
	always_ff @(posedge clk) begin
		if (ctrl.adv && v_s1) begin
			for (int j = 0; j < WK; j++) begin
				for (int i = 0; i < WK - 1; i++) begin
					win_q[j][i] <= win_q[j][i+1];
				end
				win_q[j][WK-1] <= newcol[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			rsel_s2 <= rsel_s1;
			csel_s2 <= csel_s1;
		end
	end

	// Clamped kernel taps: out-of-image positions map onto the nearest edge tap.
	always_comb begin
		for (int y = 0; y < KSIZE; y++) begin
			for (int x = 0; x < KSIZE; x++) begin
				sel_pix[y*KSIZE+x] = win_q[rsel_s2[y]][csel_s2[x]];
			end
		end
	end

endmodule

// File: rtl/icr_lane.sv
// One channel lane: kernel products, row sums and the total sum.
module icr_lane import icr_pkg::*; #(
	parameter int KSIZE = KSIZE_DEF,
	localparam int NTAP = KSIZE * KSIZE
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [CH_W-1:0]          pix [NTAP],
	input  logic signed [COEF_W-1:0] coef [NTAP],
	output logic signed [SUM_W-1:0]  sum_s5
);

	logic signed [PROD_W-1:0] prod_s3 [NTAP];
	logic signed [RSUM_W-1:0] rsum_s4 [KSIZE];
	logic signed [RSUM_W-1:0] rsum_d [KSIZE];
	logic signed [SUM_W-1:0]  sum_d;

	// Products of each tap with its coefficient.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < NTAP; t++) begin
				prod_s3[t] <= signed'({1'b0, pix[t]}) * coef[t];
			end
		end
	end

	// Row sums, then the total.
	always_comb begin
		for (int y = 0; y < KSIZE; y++) begin
			rsum_d[y] = '0;
			for (int x = 0; x < KSIZE; x++) begin
				rsum_d[y] = rsum_d[y] + RSUM_W'(prod_s3[y*KSIZE+x]);
			end
		end
		sum_d = '0;
		for (int y = 0; y < KSIZE; y++) begin
			sum_d = sum_d + SUM_W'(rsum_s4[y]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsum_s4 <= rsum_d;
			sum_s5  <= sum_d;
		end
	end

endmodule

// File: rtl/icr_checker.sv
// Port-level checks for the convolution core, bound to the top level.
module icr_checker import icr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      pix_stall,
	input logic      res_valid,
	input logic      res_stall,
	input out_item_t res_data
);

	// A stalled result stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_data))
		else $error("result payload changed while stalled");

	// Requests are only held off by a blocked result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall)
		else $error("request stalled without a blocked result");

	// Nothing is offered and nothing is held off during reset.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !res_valid && !pix_stall)
		else $error("activity during reset");

endmodule

bind image_convolution_replicate_edge_core icr_checker u_icr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_stall (pix_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);
